@@ src/lprt_pkg.sv @@
// Package with shared constants, types and the arctangent table for the ring and time tagger.
package lprt_pkg;

  localparam int unsigned MaxRingsDefault = 64;
  localparam int unsigned CordicSteps = 24;

  localparam logic [31:0] NearLimit = 32'd429497;
  localparam logic signed [27:0] Pi24 = 28'sd52707179;
  localparam logic [21:0] DegK = 22'd3754936;
  localparam logic signed [25:0] Pi16 = 26'sd205887;
  localparam logic signed [25:0] Half16 = 26'sd102944;
  localparam logic signed [25:0] ThreeHalf16 = 26'sd308831;
  localparam logic signed [25:0] TwoPi16 = 26'sd411775;

  localparam logic [2:0] RegLower = 3'd0;
  localparam logic [2:0] RegFactor = 3'd1;
  localparam logic [2:0] RegCount = 3'd2;
  localparam logic [2:0] RegPeriod = 3'd3;
  localparam logic [2:0] RegStart = 3'd4;
  localparam logic [2:0] RegEnd = 3'd5;

  localparam logic [1:0] DropNone = 2'd0;
  localparam logic [1:0] DropNear = 2'd1;
  localparam logic [1:0] DropRing = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StSqrt, StVert, StDeg, StRing, StHorz, StUnwrap, StMul, StDiv, StOut
  } state_e;

  // CORDIC datapath word: 33-bit operand times 2^16 plus growth.
  typedef logic signed [50:0] cword_t;

  typedef struct packed {
    cword_t x;
    cword_t y;
    logic signed [27:0] acc;
  } cvec_t;

  function automatic logic signed [27:0] atan_entry(input logic [4:0] i);
    logic signed [27:0] r;
    case (i)
      5'd0: r = 28'sd13176795;
      5'd1: r = 28'sd7778716;
      5'd2: r = 28'sd4110060;
      5'd3: r = 28'sd2086331;
      5'd4: r = 28'sd1047214;
      5'd5: r = 28'sd524117;
      5'd6: r = 28'sd262123;
      5'd7: r = 28'sd131069;
      5'd8: r = 28'sd65536;
      5'd9: r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/lprt_if.sv @@
// Valid/ready channel interfaces for points, results and register writes.
interface lprt_point_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;
  logic first_of_sweep;
  modport source(output valid, x_coord, y_coord, z_coord, first_of_sweep, input ready);
  modport sink(input valid, x_coord, y_coord, z_coord, first_of_sweep, output ready);
endinterface

interface lprt_result_if;
  logic valid;
  logic ready;
  logic keep;
  logic [1:0] drop_reason;
  logic [5:0] ring;
  logic signed [23:0] orientation;
  logic signed [19:0] rel_time;
  modport source(output valid, keep, drop_reason, ring, orientation, rel_time, input ready);
  modport sink(input valid, keep, drop_reason, ring, orientation, rel_time, output ready);
endinterface

interface lprt_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/lprt_cordic_cell.sv @@
// One CORDIC vectoring cell: a registered micro-rotation by a fixed table step.
module lprt_cordic_cell #(
  parameter logic [4:0] Step = 5'd0
) (
  input  logic          clk_i,
  input  lprt_pkg::cvec_t vec_i,
  output lprt_pkg::cvec_t vec_o
);
  lprt_pkg::cvec_t vec_d, vec_q;

  always_comb begin
    if (vec_i.y > 0) begin
      vec_d.x = vec_i.x + (vec_i.y >>> Step);
      vec_d.y = vec_i.y - (vec_i.x >>> Step);
      vec_d.acc = vec_i.acc + lprt_pkg::atan_entry(Step);
    end else begin
      vec_d.x = vec_i.x - (vec_i.y >>> Step);
      vec_d.y = vec_i.y + (vec_i.x >>> Step);
      vec_d.acc = vec_i.acc - lprt_pkg::atan_entry(Step);
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vec_o = vec_q;
endmodule

@@ src/lprt_cordic_chain.sv @@
// Row of CORDIC cells with prescaling of the operands and quadrant fold.
module lprt_cordic_chain (
  input  logic               clk_i,
  input  logic signed [32:0] y_i,
  input  logic signed [32:0] x_i,
  output logic signed [27:0] angle_o
);
  lprt_pkg::cvec_t head;
  lprt_pkg::cvec_t link [lprt_pkg::CordicSteps+1];
  logic signed [32:0] yf, xf;
  logic signed [27:0] acc0;
  logic zero_q [lprt_pkg::CordicSteps+1];
  logic signed [27:0] zval_q [lprt_pkg::CordicSteps+1];

  always_comb begin
    yf = y_i;
    xf = x_i;
    acc0 = '0;
    if (x_i < 0) begin
      acc0 = (y_i > 0) ? lprt_pkg::Pi24 : -lprt_pkg::Pi24;
      xf = -x_i;
      yf = -y_i;
    end
    head.x = {{2{xf[32]}}, xf, 16'd0};
    head.y = {{2{yf[32]}}, yf, 16'd0};
    head.acc = acc0;
  end

  assign link[0] = head;
  assign zero_q[0] = (y_i == 0);
  assign zval_q[0] = (x_i < 0) ? lprt_pkg::Pi24 : '0;

  for (genvar g = 0; g < lprt_pkg::CordicSteps; g++) begin : g_cell
    lprt_cordic_cell #(.Step(5'(g))) u_cell (
      .clk_i(clk_i), .vec_i(link[g]), .vec_o(link[g+1])
    );
    always_ff @(posedge clk_i) begin
      zero_q[g+1] <= zero_q[g];
      zval_q[g+1] <= zval_q[g];
    end
  end

  assign angle_o = zero_q[lprt_pkg::CordicSteps] ? zval_q[lprt_pkg::CordicSteps]
                                                  : link[lprt_pkg::CordicSteps].acc;
endmodule

@@ src/lidar_point_ring_and_time_tagger_unit.sv @@
// Top level of the lidar point ring and time tagger.
// A kept point passes through 32 square root steps, a pass through the 24-cell CORDIC row,
// the degree and ring steps, a second CORDIC pass, the unwrap and multiply steps, 44 divider
// steps and the output state; a ring drop leaves after the ring step, a near-range drop goes
// straight to the output. One point at a time: a new point is taken only after the last result transfers.
// Reset clears the control state and the half-passed flag and loads the register defaults.
module lidar_point_ring_and_time_tagger_unit #(
  parameter int unsigned MaxRings = lprt_pkg::MaxRingsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  lprt_point_if.sink    point_i,
  lprt_result_if.source result_o,
  lprt_cfg_if.sink      cfg_i
);
  localparam int unsigned RingW = $clog2(MaxRings + 1);

  // Configuration registers.
  logic signed [15:0] lower_q;
  logic [23:0] factor_q;
  logic [6:0] count_q;
  logic [15:0] period_q;
  logic signed [23:0] start_q, end_q;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= -16'sd3840;
      factor_q <= 24'd32768;
      count_q <= 7'd16;
      period_q <= 16'd6554;
      start_q <= '0;
      end_q <= 24'sd411775;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lprt_pkg::RegLower: lower_q <= cfg_i.data[15:0];
        lprt_pkg::RegFactor: factor_q <= cfg_i.data[23:0];
        lprt_pkg::RegCount: count_q <= cfg_i.data[6:0];
        lprt_pkg::RegPeriod: period_q <= cfg_i.data[15:0];
        lprt_pkg::RegStart: start_q <= cfg_i.data[23:0];
        lprt_pkg::RegEnd: end_q <= cfg_i.data[23:0];
        default: ;
      endcase
    end
  end

  lprt_pkg::state_e state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic half_q;
  logic signed [31:0] x_q, y_q, z_q;
  logic [63:0] rad_q;      // sqrt remainder / working value
  logic [63:0] root_q;
  logic [63:0] bit_q;
  logic signed [27:0] ang_q;
  logic signed [49:0] deg_q;
  logic signed [25:0] ori_q;
  logic [43:0] num_q;      // magnitude of 2*P*(o-s)+D after the sign fold
  logic [25:0] den_q;
  logic neg_q;             // sign of the folded numerator
  logic [43:0] rem_q;
  logic [43:0] quo_q;
  logic [1:0] reason_q;
  logic [5:0] ring_q;
  logic signed [19:0] rel_q;

  // CORDIC operand selection.
  logic signed [32:0] cy, cx;
  logic signed [27:0] cang;
  assign cy = (state_q == lprt_pkg::StVert) ? 33'(z_q) : 33'(y_q);
  assign cx = (state_q == lprt_pkg::StVert) ? {1'b0, root_q[31:0]} : 33'(x_q);
  lprt_cordic_chain u_chain (.clk_i(clk_i), .y_i(cy), .x_i(cx), .angle_o(cang));

  // Squares for the range test, computed once at item entry.
  logic [63:0] xx, yy, zz;
  logic [64:0] xy2, r2;
  assign xx = 64'($signed(point_i.x_coord) * $signed(point_i.x_coord));
  assign yy = 64'($signed(point_i.y_coord) * $signed(point_i.y_coord));
  assign zz = 64'($signed(point_i.z_coord) * $signed(point_i.z_coord));
  assign xy2 = 65'(xx) + 65'(yy);
  assign r2 = xy2 + 65'(zz);

  assign point_i.ready = (state_q == lprt_pkg::StIdle);
  logic take;
  assign take = point_i.valid && point_i.ready;

  // Ring mapping arithmetic.
  logic signed [49:0] diff;
  logic signed [75:0] rprod;
  logic signed [35:0] ringv;
  logic [RingW-1:0] rings;
  logic ring_bad;
  assign diff = deg_q - (50'(lower_q) <<< 16);
  assign rprod = 76'(diff) * $signed({1'b0, factor_q}) + (76'sd1 <<< 39);
  assign ringv = 36'(rprod >>> 40);
  assign rings = (32'(count_q) > MaxRings) ? RingW'(MaxRings) : RingW'(count_q);
  assign ring_bad = (ringv < 0) || (ringv >= $signed(36'(rings)));

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q + 7'd1;
    unique case (state_q)
      lprt_pkg::StIdle: begin
        cnt_d = '0;
        if (take) state_d = (r2 < 65'(lprt_pkg::NearLimit)) ? lprt_pkg::StOut
                                                             : lprt_pkg::StSqrt;
      end
      lprt_pkg::StSqrt: if (cnt_q == 7'd31) begin state_d = lprt_pkg::StVert; cnt_d = '0; end
      lprt_pkg::StVert: if (cnt_q == 7'd24) begin state_d = lprt_pkg::StDeg; cnt_d = '0; end
      lprt_pkg::StDeg: begin state_d = lprt_pkg::StRing; cnt_d = '0; end
      lprt_pkg::StRing: begin
        // A point outside the ring span goes straight to the output.
        state_d = ring_bad ? lprt_pkg::StOut : lprt_pkg::StHorz;
        cnt_d = '0;
      end
      lprt_pkg::StHorz: if (cnt_q == 7'd24) begin state_d = lprt_pkg::StUnwrap; cnt_d = '0; end
      lprt_pkg::StUnwrap: begin state_d = lprt_pkg::StMul; cnt_d = '0; end
      lprt_pkg::StMul: begin state_d = lprt_pkg::StDiv; cnt_d = '0; end
      lprt_pkg::StDiv: if (cnt_q == 7'd43) begin state_d = lprt_pkg::StOut; cnt_d = '0; end
      lprt_pkg::StOut: if (result_o.ready) state_d = lprt_pkg::StIdle;
      default: state_d = lprt_pkg::StIdle;
    endcase
  end

  // Unwrap.
  logic signed [25:0] o0, o1, s26, e26;
  logic half_n;
  assign s26 = 26'(start_q);
  assign e26 = 26'(end_q);
  always_comb begin
    o0 = -26'((cang + 28'sd128) >>> 8);
    half_n = half_q;
    if (!half_q) begin
      o1 = o0;
      if (o0 < s26 - lprt_pkg::Half16) o1 = o0 + lprt_pkg::TwoPi16;
      else if (o0 > s26 + lprt_pkg::ThreeHalf16) o1 = o0 - lprt_pkg::TwoPi16;
      if (o1 - s26 > lprt_pkg::Pi16) half_n = 1'b1;
    end else begin
      o1 = o0 + lprt_pkg::TwoPi16;
      if (o1 < e26 - lprt_pkg::ThreeHalf16) o1 = o1 + lprt_pkg::TwoPi16;
      else if (o1 > e26 + lprt_pkg::Half16) o1 = o1 - lprt_pkg::TwoPi16;
    end
  end

  // Numerator 2*P*(o-s)+D with the signs of numerator and D flipped together when D < 0.
  logic signed [25:0] dsg;
  logic signed [43:0] pmul;
  logic signed [43:0] nsg;
  assign dsg = e26 - s26;
  assign pmul = 44'($signed({1'b0, period_q}) * (ori_q - s26));
  assign nsg = (dsg < 0) ? ((-pmul) <<< 1) + 44'(-dsg) : (pmul <<< 1) + 44'(dsg);

  // Divider step on the numerator magnitude and sqrt step.
  logic [44:0] dvs;
  logic [44:0] rtrial;
  logic [44:0] rfinal;
  logic qbit;
  logic [64:0] strial;
  assign dvs = {18'd0, den_q, 1'b0};
  assign rtrial = {rem_q, 1'b0} | 45'(num_q[6'd43 - cnt_q[5:0]]);
  assign qbit = (rtrial >= dvs);
  assign rfinal = qbit ? rtrial - dvs : rtrial;
  assign strial = 65'(rad_q) - 65'(root_q + bit_q);

  // Floor division result from the quotient of the magnitude, zero for a zero divisor, then saturation.
  function automatic logic signed [19:0] relsat(input logic [25:0] d, input logic neg,
                                                input logic [43:0] q, input logic remnz);
    logic signed [45:0] r;
    r = $signed({2'b0, q});
    if (neg) r = -r - (remnz ? 46'sd1 : 46'sd0);
    if (d == '0) r = '0;
    if (r > 46'sd524287) r = 46'sd524287;
    else if (r < -46'sd524288) r = -46'sd524288;
    return r[19:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lprt_pkg::StIdle;
      cnt_q <= '0;
      half_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (take && point_i.first_of_sweep) half_q <= 1'b0;
      if (state_q == lprt_pkg::StUnwrap) half_q <= half_n;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lprt_pkg::StIdle: if (take) begin
        x_q <= point_i.x_coord;
        y_q <= point_i.y_coord;
        z_q <= point_i.z_coord;
        rad_q <= xy2[63:0];
        root_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
        reason_q <= (r2 < 65'(lprt_pkg::NearLimit)) ? lprt_pkg::DropNear : lprt_pkg::DropNone;
        ring_q <= '0;
        ori_q <= '0;
        rel_q <= '0;
      end
      lprt_pkg::StSqrt: begin
        if (!strial[64]) begin
          rad_q <= strial[63:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      lprt_pkg::StVert: ang_q <= cang;
      lprt_pkg::StDeg: deg_q <= 50'((ang_q * $signed({1'b0, lprt_pkg::DegK}) + 50'sd32768) >>> 16);
      lprt_pkg::StRing: begin
        if (ring_bad) reason_q <= lprt_pkg::DropRing;
        else ring_q <= ringv[5:0];
      end
      lprt_pkg::StHorz: ;
      lprt_pkg::StUnwrap: ori_q <= o1;
      lprt_pkg::StMul: begin
        neg_q <= nsg < 0;
        den_q <= (dsg < 0) ? 26'(-dsg) : 26'(dsg);
        num_q <= (nsg < 0) ? -nsg : nsg;
        rem_q <= '0;
        quo_q <= '0;
      end
      lprt_pkg::StDiv: begin
        rem_q <= rfinal[43:0];
        quo_q <= {quo_q[42:0], qbit};
        if (cnt_q == 7'd43) rel_q <= relsat(den_q, neg_q, {quo_q[42:0], qbit}, rfinal != '0);
      end
      default: ;
    endcase
  end

  assign result_o.valid = (state_q == lprt_pkg::StOut);
  assign result_o.keep = (reason_q == lprt_pkg::DropNone);
  assign result_o.drop_reason = reason_q;
  assign result_o.ring = ring_q;
  assign result_o.orientation = (ori_q > 26'sd8388607) ? 24'sd8388607 :
                                (ori_q < -26'sd8388608) ? -24'sd8388608 : ori_q[23:0];
  assign result_o.rel_time = rel_q;

`ifndef SYNTHESIS
  // A waiting result keeps its payload until the transfer.
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |=> result_o.valid &&
      $stable({result_o.keep, result_o.drop_reason, result_o.ring, result_o.orientation,
               result_o.rel_time}));

  // Input is taken only while no result is pending.
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(point_i.ready && result_o.valid));

  // Keep is set exactly when there is no drop reason.
  a_keep_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.keep == (result_o.drop_reason == lprt_pkg::DropNone)));

  // Only the defined drop reasons appear.
  a_reason_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.drop_reason <= lprt_pkg::DropRing));
`endif
endmodule
